FILE: rtl/led_panel_quarter_scan_driver_macros.svh
// Assertion macros shared by the quarter-scan driver modules.
`ifndef LED_PANEL_QUARTER_SCAN_DRIVER_MACROS_SVH
`define LED_PANEL_QUARTER_SCAN_DRIVER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPQSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPQSD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPQSD_ASSERT(label, prop, msg)
`define LPQSD_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: rtl/lpqsd_pkg.sv
// Types, constants and control store of the quarter-scan driver.
`timescale 1ns / 1ps
package lpqsd_pkg;

  localparam int PANEL_COUNT = 2;
  localparam int PANEL_ROWS  = 16;
  localparam int ROW_BYTES   = 4 * PANEL_COUNT;
  localparam int PANEL_WIDTH = 32 * PANEL_COUNT;
  localparam int STORE_BYTES = PANEL_ROWS * ROW_BYTES;
  localparam int SCAN_BYTES  = PANEL_ROWS * PANEL_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t STORE_LAST = addr_t'(STORE_BYTES - 1);
  localparam addr_t SCAN_LAST  = addr_t'(SCAN_BYTES - 1);

  localparam logic [7:0] BYTE_DARK = 8'hFF;
  localparam logic [7:0] BIT_MSB   = 8'h80;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SET_RD = 3'd1;
  localparam step_t STEP_SET_WR = 3'd2;
  localparam step_t STEP_CLEAR  = 3'd3;
  localparam step_t STEP_SCAN   = 3'd4;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_DISPATCH,
    SEQ_LOOP_FILL,
    SEQ_LOOP_SCAN
  } seq_t;

  typedef struct packed {
    logic  ready;
    logic  rd_rmw;
    logic  wr_rmw;
    logic  wr_fill;
    logic  scan_rd;
    seq_t  seq;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic  ready;
    logic  load_pixel;
    logic  rd_rmw;
    logic  wr_rmw;
    logic  wr_fill;
    logic  scan_load;
    logic  scan_last;
    addr_t count;
  } ctl_t;

  typedef struct packed {
    logic can_load;
    logic coord_ok;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t uw;
    uw = '{ready: 1'b0, rd_rmw: 1'b0, wr_rmw: 1'b0, wr_fill: 1'b0, scan_rd: 1'b0,
           seq: SEQ_GOTO, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        uw.ready = 1'b1;
        uw.seq   = SEQ_DISPATCH;
      end
      STEP_SET_RD: begin
        uw.rd_rmw = 1'b1;
        uw.seq    = SEQ_NEXT;
      end
      STEP_SET_WR: begin
        uw.wr_rmw = 1'b1;
        uw.seq    = SEQ_GOTO;
        uw.target = STEP_IDLE;
      end
      STEP_CLEAR: begin
        uw.wr_fill = 1'b1;
        uw.seq     = SEQ_LOOP_FILL;
        uw.target  = STEP_IDLE;
      end
      STEP_SCAN: begin
        uw.scan_rd = 1'b1;
        uw.seq     = SEQ_LOOP_SCAN;
        uw.target  = STEP_IDLE;
      end
      default: begin
        uw.seq    = SEQ_GOTO;
        uw.target = STEP_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

FILE: rtl/lpqsd_if.sv
// Command and shift-byte channel interfaces of the quarter-scan driver.
`timescale 1ns / 1ps
interface lpqsd_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [7:0] pixel_x;
  logic signed [7:0] pixel_y;
  logic              pixel_lit;

  modport source(output valid, output operation, output pixel_x, output pixel_y,
                 output pixel_lit, input ready);
  modport sink(input valid, input operation, input pixel_x, input pixel_y,
               input pixel_lit, output ready);
endinterface

interface lpqsd_shift_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_byte;
  logic [1:0] row_select;
  logic       latch_now;

  modport source(output valid, output shift_byte, output row_select, output latch_now,
                 input ready);
  modport sink(input valid, input shift_byte, input row_select, input latch_now,
               output ready);
endinterface

FILE: rtl/lpqsd_sequencer.sv
// Microcode sequencer: step counter, control store lookup and loop counter.
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_macros.svh"
module lpqsd_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic [1:0]        operation,
  input  lpqsd_pkg::stat_t  stat,
  output lpqsd_pkg::ctl_t   ctl
);

  lpqsd_pkg::step_t  pc;
  lpqsd_pkg::step_t  pc_next;
  lpqsd_pkg::addr_t  count;
  lpqsd_pkg::addr_t  count_next;
  lpqsd_pkg::ucode_t uw;
  logic              accept;
  logic              scan_go;

  assign uw      = lpqsd_pkg::ucode_rom(pc);
  assign accept  = uw.ready && cmd_valid;
  assign scan_go = uw.scan_rd && stat.can_load;

  always_comb begin
    ctl.ready      = uw.ready;
    ctl.load_pixel = accept && (operation == lpqsd_pkg::OP_SET);
    ctl.rd_rmw     = uw.rd_rmw;
    ctl.wr_rmw     = uw.wr_rmw;
    ctl.wr_fill    = uw.wr_fill;
    ctl.scan_load  = scan_go;
    ctl.scan_last  = scan_go && (count == lpqsd_pkg::SCAN_LAST);
    ctl.count      = count;
  end

  always_comb begin
    if (accept) begin
      count_next = '0;
    end else if (uw.wr_fill || scan_go) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    pc_next = pc;
    case (uw.seq)
      lpqsd_pkg::SEQ_NEXT:  pc_next = pc + 1'b1;
      lpqsd_pkg::SEQ_GOTO:  pc_next = uw.target;
      lpqsd_pkg::SEQ_DISPATCH: begin
        if (accept) begin
          unique case (operation)
            lpqsd_pkg::OP_SET: begin
              pc_next = stat.coord_ok ? lpqsd_pkg::STEP_SET_RD : lpqsd_pkg::STEP_IDLE;
            end
            lpqsd_pkg::OP_CLEAR: pc_next = lpqsd_pkg::STEP_CLEAR;
            lpqsd_pkg::OP_SCAN:  pc_next = lpqsd_pkg::STEP_SCAN;
            default:             pc_next = lpqsd_pkg::STEP_IDLE;
          endcase
        end
      end
      lpqsd_pkg::SEQ_LOOP_FILL: begin
        if (count == lpqsd_pkg::STORE_LAST) begin
          pc_next = uw.target;
        end
      end
      lpqsd_pkg::SEQ_LOOP_SCAN: begin
        if (ctl.scan_last) begin
          pc_next = uw.target;
        end
      end
      default: pc_next = lpqsd_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= lpqsd_pkg::STEP_CLEAR;
      count <= '0;
    end else begin
      pc    <= pc_next;
      count <= count_next;
    end
  end

  `LPQSD_ASSERT_RST(a_reset_starts_clear,
    rst |=> (pc == lpqsd_pkg::STEP_CLEAR && count == '0), "reset must start the clearing pass")
  `LPQSD_ASSERT(a_accept_zeroes_count, accept |=> (count == '0),
    "an accepted item must restart the loop counter")
  `LPQSD_ASSERT(a_fill_ends_idle,
    (uw.wr_fill && count == lpqsd_pkg::STORE_LAST) |=> (pc == lpqsd_pkg::STEP_IDLE),
    "the clearing pass must return to idle after the last byte")

endmodule

FILE: rtl/lpqsd_datapath.sv
// Frame store, pixel update logic, scan addressing and output register.
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_macros.svh"
module lpqsd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lpqsd_pkg::ctl_t   ctl,
  input  logic signed [7:0] pixel_x,
  input  logic signed [7:0] pixel_y,
  input  logic              pixel_lit,
  output lpqsd_pkg::stat_t  stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        shift_byte,
  output logic [1:0]        row_select,
  output logic              latch_now
);

  logic [7:0]       mem [lpqsd_pkg::STORE_BYTES];
  lpqsd_pkg::addr_t pix_addr;
  logic [7:0]       pix_mask;
  logic             pix_lit;
  logic [7:0]       rmw_byte;
  logic [1:0]       scan_phase;
  logic [3:0]       scan_line;
  lpqsd_pkg::addr_t scan_addr;
  lpqsd_pkg::addr_t new_addr;
  lpqsd_pkg::addr_t rd_addr;
  lpqsd_pkg::addr_t wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en;

  assign stat.can_load = !out_valid || out_ready;
  assign stat.coord_ok = !pixel_x[7] && (pixel_x[6:0] < 7'(lpqsd_pkg::PANEL_WIDTH))
                      && !pixel_y[7] && (pixel_y[6:0] < 7'(lpqsd_pkg::PANEL_ROWS));

  assign new_addr = lpqsd_pkg::addr_t'(pixel_y[3:0])
                  * lpqsd_pkg::addr_t'(lpqsd_pkg::ROW_BYTES)
                  + lpqsd_pkg::addr_t'(pixel_x[6:3]);

  // Rows r+12, r+8, r+4 and r in turn for each column byte.
  assign scan_line = {~ctl.count[1:0], scan_phase};
  assign scan_addr = lpqsd_pkg::addr_t'(scan_line)
                   * lpqsd_pkg::addr_t'(lpqsd_pkg::ROW_BYTES)
                   + (ctl.count >> 2);

  assign rd_addr = ctl.scan_load ? scan_addr : pix_addr;
  assign wr_addr = ctl.wr_fill ? ctl.count : pix_addr;
  assign wr_en   = ctl.wr_fill || ctl.wr_rmw;

  always_comb begin
    if (ctl.wr_fill) begin
      wr_data = lpqsd_pkg::BYTE_DARK;
    end else if (pix_lit) begin
      wr_data = rmw_byte & ~pix_mask;
    end else begin
      wr_data = rmw_byte | pix_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_rmw) begin
      rmw_byte <= mem[rd_addr];
    end
    if (ctl.scan_load) begin
      shift_byte <= mem[rd_addr];
      row_select <= scan_phase;
      latch_now  <= ctl.scan_last;
    end
    if (ctl.load_pixel) begin
      pix_addr <= new_addr;
      pix_mask <= lpqsd_pkg::BIT_MSB >> pixel_x[2:0];
      pix_lit  <= pixel_lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      scan_phase <= '0;
    end else begin
      if (ctl.scan_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.scan_last) begin
        scan_phase <= scan_phase + 1'b1;
      end
    end
  end

  `LPQSD_ASSERT(a_no_rw_clash, !(ctl.scan_load && wr_en),
    "a scan read must not share a cycle with a store write")
  `LPQSD_ASSERT(a_no_overwrite, ctl.scan_load |-> (!out_valid || out_ready),
    "a waiting output byte must not be overwritten")
  `LPQSD_ASSERT(a_row_advance, ctl.scan_last |=> (scan_phase == 2'($past(scan_phase) + 2'd1)),
    "the scan row must advance after the last byte of a tick")

endmodule

FILE: rtl/led_panel_quarter_scan_driver.sv
// Top level of the quarter-scan LED panel driver.
//
// The cmd channel takes one item per operation: set pixel, clear the frame
// to dark, or scan tick. The shift channel returns one item per frame byte
// with its row select, and marks the last byte of a tick for latching.
// Neither a set pixel, on or off the panel, nor a clear returns an item.
// A scan tick reads one byte of the frame store per cycle while the shift
// receiver does not stall, so it returns 16 bytes per panel (32 for two
// panels), and the next command is taken in the cycle after the last byte
// is read. The single read port of the frame store sets this rate. A clear
// or a set pixel may be taken while the last byte of a tick still waits on
// the shift channel. When the shift receiver stalls, the scan sequence
// pauses on the waiting byte and resumes when it is taken. No byte is
// dropped or repeated.
// After reset the block runs a clearing pass over the whole frame store,
// one byte per cycle, with cmd ready held low; the scan row starts at zero.
`timescale 1ns / 1ps
module led_panel_quarter_scan_driver (
  input  logic                 clk,
  input  logic                 rst,
  lpqsd_cmd_if.sink            cmd,
  lpqsd_shift_if.source        shift
);

  lpqsd_pkg::ctl_t  ctl;
  lpqsd_pkg::stat_t stat;

  assign cmd.ready = ctl.ready;

  lpqsd_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .operation (cmd.operation),
    .stat      (stat),
    .ctl       (ctl)
  );

  lpqsd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .pixel_x    (cmd.pixel_x),
    .pixel_y    (cmd.pixel_y),
    .pixel_lit  (cmd.pixel_lit),
    .stat       (stat),
    .out_valid  (shift.valid),
    .out_ready  (shift.ready),
    .shift_byte (shift.shift_byte),
    .row_select (shift.row_select),
    .latch_now  (shift.latch_now)
  );

endmodule
